@@ sv/sha1_pkg.sv @@
// ============================================================================
// SHA-1 hash core package
// Shared types, command structure and constants of the SHA-1 hash core.
// ============================================================================
package sha1_pkg;

    localparam int ROUNDS     = 80;
    localparam int NUM_WORDS  = 5;
    localparam int COUNT_W    = 61;
    localparam int LEN_W      = 64;

    localparam logic [5:0] POS_LAST = 6'd63;
    localparam logic [5:0] POS_LEN  = 6'd56;
    localparam logic [2:0] WORD_LAST = 3'd4;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_FOLD,
        S_OUT
    } sha1_state_t;

    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_MARK,
        SEL_ZERO,
        SEL_LEN
    } byte_sel_t;

    typedef struct packed {
        logic       put;
        byte_sel_t  sel;
        logic       load_len;
        logic       round;
        logic [6:0] round_idx;
        logic       fold;
        logic       clear;
        logic [2:0] word_sel;
    } sha1_cmd_t;

endpackage

@@ sv/sha1_msg_if.sv @@
// ============================================================================
// SHA-1 message channel
// Carries one message byte per transfer with its byte-present and last flags.
// ============================================================================
interface sha1_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output data_byte, output has_byte, output last,
                    input ready);
    modport sink (input valid, input data_byte, input has_byte, input last,
                  output ready);
endinterface

@@ sv/sha1_digest_if.sv @@
// ============================================================================
// SHA-1 digest channel
// Carries one 32-bit digest word per transfer with its index and end flag.
// ============================================================================
interface sha1_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

@@ sv/sha1_dp.sv @@
// ============================================================================
// SHA-1 datapath
// Message schedule shift line, round registers, chaining value, byte count
// and message length register.
// ============================================================================
module sha1_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          data_byte,
    input  sha1_pkg::sha1_cmd_t cmd,
    output logic [5:0]          pos,
    output logic [31:0]         digest_word
);
    import sha1_pkg::*;

    logic [31:0]        w_reg [16];
    logic [23:0]        acc_reg;
    logic [31:0]        a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]        h_reg [NUM_WORDS];
    logic [COUNT_W-1:0] count_reg;
    logic [5:0]         pos_reg;
    logic [LEN_W-1:0]   len_reg;

    logic [7:0]  put_byte;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_val;
    logic [31:0] sched_x;
    logic [31:0] sched_w;
    logic        word_done;
    logic        block_done;

    always_comb
    begin
        unique case (cmd.sel)
            SEL_DATA: put_byte = data_byte;
            SEL_MARK: put_byte = PAD_MARK;
            SEL_ZERO: put_byte = 8'h00;
            SEL_LEN:  put_byte = len_reg[LEN_W-1 -: 8];
            default:  put_byte = 8'h00;
        endcase
    end

    assign word_done  = cmd.put && (pos_reg[1:0] == 2'b11);
    assign block_done = cmd.put && (pos_reg == POS_LAST);

    always_comb
    begin
        if (cmd.round_idx < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K0;
        end
        else if (cmd.round_idx < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K1;
        end
        else if (cmd.round_idx < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K3;
        end
    end

    assign t_val   = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_reg[0];
    assign sched_x = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign sched_w = {sched_x[30:0], sched_x[31]};

    // The oldest word sits at index 0, so round t always consumes w_reg[0].
    always_ff @(posedge clk)
    begin
        if (word_done || cmd.round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= word_done ? {acc_reg, put_byte} : sched_w;
        end
        if (cmd.put)
        begin
            acc_reg <= {acc_reg[15:0], put_byte};
        end
    end

    always_ff @(posedge clk)
    begin
        if (block_done)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        else if (cmd.round)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        if (cmd.load_len)
        begin
            len_reg <= {count_reg, 3'b000};
        end
        else if (cmd.put && (cmd.sel == SEL_LEN))
        begin
            len_reg <= {len_reg[LEN_W-9:0], 8'h00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg[0]  <= H0_INIT;
            h_reg[1]  <= H1_INIT;
            h_reg[2]  <= H2_INIT;
            h_reg[3]  <= H3_INIT;
            h_reg[4]  <= H4_INIT;
            count_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                h_reg[0]  <= H0_INIT;
                h_reg[1]  <= H1_INIT;
                h_reg[2]  <= H2_INIT;
                h_reg[3]  <= H3_INIT;
                h_reg[4]  <= H4_INIT;
                count_reg <= '0;
                pos_reg   <= '0;
            end
            else
            begin
                if (cmd.fold)
                begin
                    h_reg[0] <= h_reg[0] + a_reg;
                    h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg;
                    h_reg[3] <= h_reg[3] + d_reg;
                    h_reg[4] <= h_reg[4] + e_reg;
                end
                if (cmd.put)
                begin
                    pos_reg <= pos_reg + 6'd1;
                end
                if (cmd.put && (cmd.sel == SEL_DATA))
                begin
                    count_reg <= count_reg + COUNT_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        unique case (cmd.word_sel)
            3'd0:    digest_word = h_reg[0];
            3'd1:    digest_word = h_reg[1];
            3'd2:    digest_word = h_reg[2];
            3'd3:    digest_word = h_reg[3];
            3'd4:    digest_word = h_reg[4];
            default: digest_word = h_reg[0];
        endcase
    end

    assign pos = pos_reg;

endmodule

@@ sv/sha1_ctrl.sv @@
// ============================================================================
// SHA-1 controller
// Sequences byte intake, padding, the 80 rounds, the fold into the chaining
// value and the five digest word transfers.
// ============================================================================
module sha1_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_has_byte,
    input  logic                in_last,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  logic [5:0]          pos,
    output sha1_pkg::sha1_cmd_t cmd
);
    import sha1_pkg::*;

    sha1_state_t state_reg, state_next;
    logic        pad_reg, pad_next;
    logic        first_reg, first_next;
    logic        lenph_reg, lenph_next;
    logic        fin_reg, fin_next;
    logic [6:0]  round_reg, round_next;
    logic [2:0]  word_reg, word_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pad_reg   <= 1'b0;
            first_reg <= 1'b0;
            lenph_reg <= 1'b0;
            fin_reg   <= 1'b0;
            round_reg <= '0;
            word_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pad_reg   <= pad_next;
            first_reg <= first_next;
            lenph_reg <= lenph_next;
            fin_reg   <= fin_next;
            round_reg <= round_next;
            word_reg  <= word_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pad_next   = pad_reg;
        first_next = first_reg;
        lenph_next = lenph_reg;
        fin_next   = fin_reg;
        round_next = round_reg;
        word_next  = word_reg;
        cmd        = '0;
        cmd.sel    = SEL_DATA;
        in_ready   = 1'b0;
        out_valid  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_has_byte)
                    begin
                        cmd.put = 1'b1;
                        if (pos == POS_LAST)
                        begin
                            state_next = S_ROUND;
                            pad_next   = in_last;
                            first_next = in_last;
                        end
                        else if (in_last)
                        begin
                            state_next = S_PAD;
                            pad_next   = 1'b1;
                            first_next = 1'b1;
                        end
                    end
                    else if (in_last)
                    begin
                        state_next = S_PAD;
                        pad_next   = 1'b1;
                        first_next = 1'b1;
                    end
                end
            end

            S_PAD:
            begin
                cmd.put = 1'b1;
                // The marker byte comes first even when it lands at offset 56.
                if (first_reg)
                begin
                    cmd.sel      = SEL_MARK;
                    cmd.load_len = 1'b1;
                    first_next   = 1'b0;
                end
                else if (lenph_reg || (pos == POS_LEN))
                begin
                    cmd.sel    = SEL_LEN;
                    lenph_next = 1'b1;
                    if (pos == POS_LAST)
                    begin
                        fin_next = 1'b1;
                    end
                end
                else
                begin
                    cmd.sel = SEL_ZERO;
                end
                if (pos == POS_LAST)
                begin
                    state_next = S_ROUND;
                end
            end

            S_ROUND:
            begin
                cmd.round     = 1'b1;
                cmd.round_idx = round_reg;
                if (round_reg == 7'(ROUNDS - 1))
                begin
                    round_next = '0;
                    state_next = S_FOLD;
                end
                else
                begin
                    round_next = round_reg + 7'd1;
                end
            end

            S_FOLD:
            begin
                cmd.fold = 1'b1;
                priority if (fin_reg)
                begin
                    state_next = S_OUT;
                    word_next  = '0;
                end
                else if (pad_reg)
                begin
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_OUT:
            begin
                out_valid    = 1'b1;
                cmd.word_sel = word_reg;
                if (out_ready)
                begin
                    if (word_reg == WORD_LAST)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                        pad_next   = 1'b0;
                        first_next = 1'b0;
                        lenph_next = 1'b0;
                        fin_next   = 1'b0;
                        word_next  = '0;
                    end
                    else
                    begin
                        word_next = word_reg + 3'd1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_fin_in_pad: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> pad_reg)
        else $error("length written outside of padding");

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> (round_reg < 7'(ROUNDS)))
        else $error("round counter out of range");

    a_block_starts_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.put && (pos == POS_LAST)) |=> (state_reg == S_ROUND))
        else $error("full block did not start the rounds");

    a_out_after_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> (fin_reg && (word_reg <= WORD_LAST)))
        else $error("digest output without a finished message");
`endif

endmodule

@@ sv/sha1_hash_core.sv @@
// ============================================================================
// SHA-1 hash core
// Hashes a byte stream and returns the 160-bit digest as five 32-bit words.
// ============================================================================
//  Channel   Direction  Payload                                Transfer when
//  msg       in         data_byte[7:0], has_byte, last         valid && ready
//  digest    out        digest_word[31:0], word_index[2:0],     valid && ready
//                       last_word
//
//  The byte that completes a 64-byte block starts the 80 rounds on one
//  shared round unit, followed by the fold.
//  A last item adds padding plus one or two blocks of rounds, then five
//  digest transfers. Input is taken only in the idle state.
//  Reset is asynchronous and active low; no clearing pass is needed.
//  A stalled digest word holds until it is taken.
module sha1_hash_core (
    input  logic           clk,
    input  logic           rst_n,
    sha1_msg_if.sink       msg,
    sha1_digest_if.source  digest
);
    import sha1_pkg::*;

    sha1_cmd_t   cmd;
    logic [5:0]  pos;

    sha1_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (msg.valid),
        .in_has_byte (msg.has_byte),
        .in_last     (msg.last),
        .in_ready    (msg.ready),
        .out_valid   (digest.valid),
        .out_ready   (digest.ready),
        .pos         (pos),
        .cmd         (cmd)
    );

    sha1_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (msg.data_byte),
        .cmd         (cmd),
        .pos         (pos),
        .digest_word (digest.digest_word)
    );

    assign digest.word_index = cmd.word_sel;
    assign digest.last_word  = (cmd.word_sel == WORD_LAST);

endmodule
